/* src/vpfe_pkg.sv */
// Shared types and constants for the video payload frame extractor.
// No dependencies; every other file in src depends on this package.
package vpfe_pkg;

	localparam int CMD_W      = 2;
	localparam int BYTE_W     = 8;
	localparam int ST_W       = 2;
	localparam int HDR_W      = 8;
	localparam int POS_W      = 12;
	localparam int SLOT_W     = 16;
	localparam int CNT_W      = 28;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Request commands
	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EMPTY = 2'd2;

	// Result status codes
	localparam logic [ST_W-1:0] ST_RUNNING  = 2'd0;
	localparam logic [ST_W-1:0] ST_DONE     = 2'd1;
	localparam logic [ST_W-1:0] ST_NO_FRAME = 2'd2;
	localparam logic [ST_W-1:0] ST_OVERSIZE = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKETS = 1'b1;

	localparam logic [POS_W-1:0]  MAX_PAYLOAD_RST = 12'd1024;
	localparam logic [SLOT_W-1:0] MAX_PACKETS_RST = 16'd10000;

	// End-of-frame flag position in header byte 1
	localparam int EOF_BIT = 1;

	localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
	localparam logic [SLOT_W-1:0] SLOT_MAX = {SLOT_W{1'b1}};
	localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [BYTE_W-1:0] data_byte;
		logic              last_in_packet;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]  max_payload;
		logic [SLOT_W-1:0] max_packets;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic              take;
	} stage_ctl_t;

endpackage

/* src/vpfe_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on vpfe_pkg for field widths.
interface vpfe_in_if;
	logic                           valid;
	logic                           ready;
	logic [vpfe_pkg::CMD_W-1:0]     command;
	logic [vpfe_pkg::BYTE_W-1:0]    data_byte;
	logic                           last_in_packet;

	modport source (output valid, command, data_byte, last_in_packet, input ready);
	modport sink   (input valid, command, data_byte, last_in_packet, output ready);
endinterface

interface vpfe_out_if;
	logic                           valid;
	logic                           ready;
	logic                           has_byte;
	logic [vpfe_pkg::BYTE_W-1:0]    payload_byte;
	logic [vpfe_pkg::ST_W-1:0]      status;
	logic [vpfe_pkg::CNT_W-1:0]     frame_length;

	modport source (output valid, has_byte, payload_byte, status, frame_length, input ready);
	modport sink   (input valid, has_byte, payload_byte, status, frame_length, output ready);
endinterface

/* src/vpfe_in_stage.sv */
// Input register for incoming requests.
// Depends on vpfe_pkg and vpfe_in_if.
module vpfe_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	vpfe_in_if.sink              packet,
	input  logic                 take,
	output vpfe_pkg::stage_ctl_t ctl_s1,
	output vpfe_pkg::item_t      item_s1
);
	import vpfe_pkg::*;

	logic valid_s1;

	// Refill when empty or whenever the held request leaves this cycle
	assign packet.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (packet.ready) begin
			valid_s1 <= packet.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (packet.ready && packet.valid) begin
			item_s1.command        <= packet.command;
			item_s1.data_byte      <= packet.data_byte;
			item_s1.last_in_packet <= packet.last_in_packet;
		end
	end

	assign ctl_s1.valid = valid_s1;
	assign ctl_s1.take  = take;
endmodule

/* src/vpfe_core.sv */
// Capture state, header strip logic and result register.
// Depends on vpfe_pkg and vpfe_out_if.
module vpfe_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vpfe_pkg::cfg_t       cfg,
	input  logic                 valid_s1,
	input  vpfe_pkg::item_t      item_s1,
	output logic                 take,
	vpfe_out_if.source           payload
);
	import vpfe_pkg::*;

	logic              active_q, saving_q, eof_q;
	logic [HDR_W-1:0]  hdr_q;
	logic [POS_W-1:0]  pos_q;
	logic [SLOT_W-1:0] pkt_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              active_n, saving_n, eof_n;
	logic [HDR_W-1:0]  hdr_n;
	logic [POS_W-1:0]  pos_n;
	logic [SLOT_W-1:0] pkt_n;
	logic [CNT_W-1:0]  cnt_n;

	logic              in_payload, slot_end, fire, has;
	logic [ST_W-1:0]   st;

	logic              out_valid_q, out_has_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [ST_W-1:0]   out_st_q;
	logic [CNT_W-1:0]  out_len_q;

	assign take = valid_s1 && (!out_valid_q || payload.ready);

	always_comb begin
		active_n   = active_q;
		saving_n   = saving_q;
		eof_n      = eof_q;
		hdr_n      = hdr_q;
		pos_n      = pos_q;
		pkt_n      = pkt_q;
		cnt_n      = cnt_q;
		in_payload = 1'b0;
		slot_end   = 1'b0;
		has        = 1'b0;
		st         = ST_RUNNING;
		if (take) begin
			case (item_s1.command)
				CMD_START: begin
					active_n = 1'b1;
					saving_n = 1'b0;
					eof_n    = 1'b0;
					hdr_n    = '0;
					pos_n    = '0;
					pkt_n    = '0;
					cnt_n    = '0;
				end
				CMD_BYTE: begin
					if (active_q) begin
						if (pos_q == '0) hdr_n = item_s1.data_byte;
						if (pos_q == POS_W'(1)) eof_n = item_s1.data_byte[EOF_BIT];
						in_payload = saving_q && (pos_q >= {{(POS_W-HDR_W){1'b0}}, hdr_n});
						if (in_payload && (pos_q >= cfg.max_payload)) begin
							active_n = 1'b0;
							st       = ST_OVERSIZE;
						end else begin
							has = in_payload;
							if (in_payload && (cnt_q != CNT_MAX)) cnt_n = cnt_q + 1'b1;
							if (pos_q != POS_MAX) pos_n = pos_q + 1'b1;
							if (item_s1.last_in_packet) begin
								slot_end = 1'b1;
								if (eof_n) begin
									if (saving_q) begin
										st       = ST_DONE;
										active_n = 1'b0;
									end else begin
										saving_n = 1'b1;
									end
								end
							end
						end
					end
				end
				CMD_EMPTY: begin
					slot_end = active_q;
				end
				default: ;
			endcase
		end
		if (slot_end) begin
			pos_n = '0;
			eof_n = 1'b0;
			if (pkt_q != SLOT_MAX) pkt_n = pkt_q + 1'b1;
			if ((st == ST_RUNNING) && (pkt_n >= cfg.max_packets)) begin
				st       = ST_NO_FRAME;
				active_n = 1'b0;
			end
		end
		fire = has || (st != ST_RUNNING);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			saving_q <= 1'b0;
			eof_q    <= 1'b0;
			hdr_q    <= '0;
			pos_q    <= '0;
			pkt_q    <= '0;
			cnt_q    <= '0;
		end else begin
			active_q <= active_n;
			saving_q <= saving_n;
			eof_q    <= eof_n;
			hdr_q    <= hdr_n;
			pos_q    <= pos_n;
			pkt_q    <= pkt_n;
			cnt_q    <= cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && fire) begin
			out_valid_q <= 1'b1;
		end else if (payload.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && fire) begin
			out_has_q  <= has;
			out_byte_q <= has ? item_s1.data_byte : '0;
			out_st_q   <= st;
			out_len_q  <= cnt_n;
		end
	end

	assign payload.valid        = out_valid_q;
	assign payload.has_byte     = out_has_q;
	assign payload.payload_byte = out_byte_q;
	assign payload.status       = out_st_q;
	assign payload.frame_length = out_len_q;
endmodule

/* src/video_payload_frame_extractor.sv */
// Video payload frame extractor: strips packet headers and emits one frame.
// A request is held in the input register; its result is then registered in
// the result register behind the capture logic.
// Throughput: one request per cycle while results are taken; a stalled result
// holds the core, and the input register still takes one more request.
// Reset (arst_n low): capture idle, no result pending, limits at 1024 / 10000.
module video_payload_frame_extractor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [vpfe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vpfe_pkg::CFG_DATA_W-1:0] cfg_data,
	vpfe_in_if.sink                        packet,
	vpfe_out_if.source                     payload
);
	import vpfe_pkg::*;

	cfg_t       cfg_q;
	stage_ctl_t ctl_s1;
	item_t      item_s1;
	logic       take;

	// Limits should only be rewritten while the capture path is drained; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload <= MAX_PAYLOAD_RST;
			cfg_q.max_packets <= MAX_PACKETS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data[POS_W-1:0];
				CFG_MAX_PACKETS: cfg_q.max_packets <= cfg_data[SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold each request here until the core can advance it.
	vpfe_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.packet  (packet),
		.take    (take),
		.ctl_s1  (ctl_s1),
		.item_s1 (item_s1)
	);

	// Drop header bytes, count payload, flag frame end, slot limit or oversize.
	vpfe_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s1 (ctl_s1.valid),
		.item_s1  (item_s1),
		.take     (take),
		.payload  (payload)
	);
endmodule

/* src/vpfe_checker.sv */
// Port-level checks on the result channel of the frame extractor.
// Depends on vpfe_pkg; bound to video_payload_frame_extractor below.
module vpfe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          has_byte,
	input logic [vpfe_pkg::BYTE_W-1:0]   payload_byte,
	input logic [vpfe_pkg::ST_W-1:0]     status,
	input logic [vpfe_pkg::CNT_W-1:0]    frame_length
);
	import vpfe_pkg::*;

	// Oversize abort never carries a byte
	a_abort_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OVERSIZE) |-> !has_byte)
		else $error("oversize result carries a byte");

	// A result without a byte shows a zero byte
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> (payload_byte == '0))
		else $error("empty result has nonzero byte");

	// An emitted byte is always counted
	a_byte_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_byte |-> (frame_length != '0))
		else $error("payload byte with zero frame length");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(has_byte)
			&& $stable(payload_byte) && $stable(status) && $stable(frame_length))
		else $error("stalled result changed");
endmodule

bind video_payload_frame_extractor vpfe_checker u_vpfe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (payload.valid),
	.out_ready    (payload.ready),
	.has_byte     (payload.has_byte),
	.payload_byte (payload.payload_byte),
	.status       (payload.status),
	.frame_length (payload.frame_length)
);
